// ===== src/assert_macros.svh =====
// assertion macros shared by the fresnel reflectance rtl
// no dependencies; checks compile out when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, held off while reset is high
`define FR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fresnel reflectance check failed");
// clocked check that also holds during reset
`define FR_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fresnel reflectance check failed");
`else
`define FR_ASSERT(lbl, clk, rst, prop)
`define FR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/fr_pkg.sv =====
// types and constants for the fresnel reflectance pipeline
// no dependencies
package fr_pkg;

   // one ray hit
   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [15:0]        refr_index;
   } req_type;

   // one reflectance result
   typedef struct packed {
      logic [15:0] reflectance;
      logic        total_internal;
   } rsp_type;

   // square root unit: radicand up to 2^56, root up to 2^28
   localparam int ROOT_W = 29;
   localparam int RAD_W = 2 * ROOT_W - 1;
   // side payload carried through the first root unit: c, eta_i, eta_t
   localparam int SQRT_SIDE_W = 29 + 16 + 16;

   localparam logic [15:0] UNITY_Q12 = 16'd4096;
   localparam logic [15:0] FULL_Q15 = 16'h8000;

endpackage

// ===== src/fresnel_reflectance.sv =====
// top level of the unpolarized fresnel reflectance pipeline
// depends on fr_pkg, fr_isqrt and assert_macros.svh
//
//  channel | ports                          | moves
//  --------+--------------------------------+---------------------------------
//  request | req_valid req_stall req_data   | ray direction, normal, index
//  result  | rsp_valid rsp_stall rsp_data   | reflectance, total internal flag
//
// one item enters per cycle unless the result is stalled; the pipeline holds the two 29 stage
// square root units, the 28 stage snell divider and the 17 stage divider
// for the s and p coefficients.
// synchronous reset empties every stage; payload registers are not reset.
// a stalled result freezes the whole pipeline, nothing is lost or repeated.
`include "assert_macros.svh"
module fresnel_reflectance (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  fr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fr_pkg::rsp_type rsp_data
);
   import fr_pkg::*;

   localparam int SIDE2_W = SQRT_SIDE_W + 1;
   localparam int DT_N = 28;
   localparam int DC_N = 17;
   localparam logic signed [33:0] ONE28 = 34'sd268435456;

   logic adv;
   logic out_valid_ff;

   // whole pipeline moves unless a finished item is held
   assign adv = !out_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: component products, index fixup
   logic              s1_valid_ff;
   logic signed [31:0] s1_p0_ff, s1_p1_ff, s1_p2_ff;
   logic [15:0]       s1_idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p0_ff <= req_data.dir_x * req_data.norm_x;
         s1_p1_ff <= req_data.dir_y * req_data.norm_y;
         s1_p2_ff <= req_data.dir_z * req_data.norm_z;
         s1_idx_ff <= (req_data.refr_index == 16'd0) ? 16'd1 : req_data.refr_index;
      end
   end

   // stage 2: dot product, clamp, side of the surface
   logic signed [33:0] dot_in;
   logic [28:0]        c_in;
   logic               inside_in;
   logic               s2_valid_ff;
   logic [28:0]        s2_c_ff;
   logic               s2_inside_ff;
   logic [15:0]        s2_idx_ff;
   assign dot_in = 34'(s1_p0_ff) + 34'(s1_p1_ff) + 34'(s1_p2_ff);
   always_comb begin
      priority if (dot_in > ONE28) begin
         c_in = 29'h1000_0000;
         inside_in = 1'b1;
      end else if (dot_in < -ONE28) begin
         c_in = 29'h1000_0000;
         inside_in = 1'b0;
      end else if (dot_in < 0) begin
         c_in = 29'(-dot_in);
         inside_in = 1'b0;
      end else begin
         c_in = dot_in[28:0];
         inside_in = dot_in != 0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_c_ff <= c_in;
         s2_inside_ff <= inside_in;
         s2_idx_ff <= s1_idx_ff;
      end
   end

   // stage 3: one minus cos squared, index swap
   logic               s3_valid_ff;
   logic [RAD_W-1:0]   s3_rad_ff;
   logic [SQRT_SIDE_W-1:0] s3_side_ff;
   logic [57:0]        csq_in;
   assign csq_in = {29'b0, s2_c_ff} * {29'b0, s2_c_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_rad_ff <= RAD_W'((58'(1) << 56) - csq_in);
         s3_side_ff <= s2_inside_ff ? {s2_c_ff, s2_idx_ff, UNITY_Q12}
                                    : {s2_c_ff, UNITY_Q12, s2_idx_ff};
      end
   end

   // sine of the incident angle
   logic                   r1_valid;
   logic [ROOT_W-1:0]      r1_root;
   logic [SQRT_SIDE_W-1:0] r1_side;
   fr_isqrt #(.SIDE_W(SQRT_SIDE_W)) u_sin_i (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s3_valid_ff), .in_rad(s3_rad_ff), .in_side(s3_side_ff),
      .out_valid(r1_valid), .out_root(r1_root), .out_side(r1_side)
   );

   // stage 4: snell numerator and total internal reflection test
   logic [44:0] num_in;
   logic [15:0] r1_eta_i, r1_eta_t;
   logic [28:0] r1_c;
   logic        s4_valid_ff;
   logic [44:0] s4_rem_ff;
   logic [15:0] s4_eta_i_ff, s4_eta_t_ff;
   logic [28:0] s4_c_ff;
   logic        s4_tir_ff;
   assign {r1_c, r1_eta_i, r1_eta_t} = r1_side;
   assign num_in = {29'b0, r1_eta_i} * {16'b0, r1_root};
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= r1_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_rem_ff <= num_in;
         s4_tir_ff <= num_in >= {1'b0, r1_eta_t, 28'b0};
         s4_eta_i_ff <= r1_eta_i;
         s4_eta_t_ff <= r1_eta_t;
         s4_c_ff <= r1_c;
      end
   end

   // snell divider, one quotient bit per stage
   logic [44:0]     dt_rem_ff [0:DT_N-1];
   logic [DT_N-1:0] dt_q_ff [0:DT_N-1];
   logic [15:0]     dt_eta_i_ff [0:DT_N-1];
   logic [15:0]     dt_eta_t_ff [0:DT_N-1];
   logic [28:0]     dt_c_ff [0:DT_N-1];
   logic            dt_tir_ff [0:DT_N-1];
   logic            dt_valid_ff [0:DT_N-1];
   for (genvar g = 0; g < DT_N; g++) begin : g_div_t
      localparam int K = DT_N - 1 - g;
      logic [44:0]     rem_src;
      logic [DT_N-1:0] q_src;
      logic [15:0]     eta_i_src, eta_t_src;
      logic [28:0]     c_src;
      logic            tir_src, valid_src;
      logic [44:0]     dsh;
      logic            ge;
      if (g == 0) begin : g_first
         assign rem_src = s4_rem_ff;
         assign q_src = '0;
         assign eta_i_src = s4_eta_i_ff;
         assign eta_t_src = s4_eta_t_ff;
         assign c_src = s4_c_ff;
         assign tir_src = s4_tir_ff;
         assign valid_src = s4_valid_ff;
      end else begin : g_next
         assign rem_src = dt_rem_ff[g-1];
         assign q_src = dt_q_ff[g-1];
         assign eta_i_src = dt_eta_i_ff[g-1];
         assign eta_t_src = dt_eta_t_ff[g-1];
         assign c_src = dt_c_ff[g-1];
         assign tir_src = dt_tir_ff[g-1];
         assign valid_src = dt_valid_ff[g-1];
      end
      assign dsh = 45'(eta_t_src) << K;
      assign ge = rem_src >= dsh;
      always_ff @(posedge clock) begin
         if (reset) begin
            dt_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            dt_valid_ff[g] <= valid_src;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dt_rem_ff[g] <= ge ? rem_src - dsh : rem_src;
            dt_q_ff[g] <= ge ? q_src | (DT_N'(1) << K) : q_src;
            dt_eta_i_ff[g] <= eta_i_src;
            dt_eta_t_ff[g] <= eta_t_src;
            dt_c_ff[g] <= c_src;
            dt_tir_ff[g] <= tir_src;
         end
      end
   end

   // stage 5: one minus sin_t squared
   logic [55:0]        stsq_in;
   logic               s5_valid_ff;
   logic [RAD_W-1:0]   s5_rad_ff;
   logic [SIDE2_W-1:0] s5_side_ff;
   assign stsq_in = {28'b0, dt_q_ff[DT_N-1]} * {28'b0, dt_q_ff[DT_N-1]};
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= dt_valid_ff[DT_N-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_rad_ff <= (RAD_W'(1) << 56) - RAD_W'(stsq_in);
         s5_side_ff <= {dt_c_ff[DT_N-1], dt_eta_i_ff[DT_N-1], dt_eta_t_ff[DT_N-1],
                        dt_tir_ff[DT_N-1]};
      end
   end

   // cosine of the transmitted angle
   logic               r2_valid;
   logic [ROOT_W-1:0]  r2_root;
   logic [SIDE2_W-1:0] r2_side;
   fr_isqrt #(.SIDE_W(SIDE2_W)) u_cos_t (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s5_valid_ff), .in_rad(s5_rad_ff), .in_side(s5_side_ff),
      .out_valid(r2_valid), .out_root(r2_root), .out_side(r2_side)
   );

   // stage 6: the four index times cosine products
   logic [28:0] r2_c;
   logic [15:0] r2_eta_i, r2_eta_t;
   logic        r2_tir;
   logic        s6_valid_ff, s6_tir_ff;
   logic [44:0] s6_a_ff, s6_b_ff, s6_d_ff, s6_e_ff;
   assign {r2_c, r2_eta_i, r2_eta_t, r2_tir} = r2_side;
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= r2_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_a_ff <= {29'b0, r2_eta_t} * {16'b0, r2_c};
         s6_b_ff <= {29'b0, r2_eta_i} * {16'b0, r2_root};
         s6_d_ff <= {29'b0, r2_eta_i} * {16'b0, r2_c};
         s6_e_ff <= {29'b0, r2_eta_t} * {16'b0, r2_root};
         s6_tir_ff <= r2_tir;
      end
   end

   // stage 7: differences and sums for the s and p coefficients
   logic        s7_valid_ff, s7_tir_ff;
   logic [61:0] s7_rs_rem_ff, s7_rp_rem_ff;
   logic [45:0] s7_ss_ff, s7_sp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s7_rs_rem_ff <= {1'b0, (s6_a_ff > s6_b_ff) ? s6_a_ff - s6_b_ff
                                                    : s6_b_ff - s6_a_ff, 16'b0};
         s7_rp_rem_ff <= {1'b0, (s6_d_ff > s6_e_ff) ? s6_d_ff - s6_e_ff
                                                    : s6_e_ff - s6_d_ff, 16'b0};
         s7_ss_ff <= {1'b0, s6_a_ff} + {1'b0, s6_b_ff};
         s7_sp_ff <= {1'b0, s6_d_ff} + {1'b0, s6_e_ff};
         s7_tir_ff <= s6_tir_ff;
      end
   end

   // coefficient dividers, s and p side by side
   logic [61:0]     dc_rs_rem_ff [0:DC_N-1];
   logic [61:0]     dc_rp_rem_ff [0:DC_N-1];
   logic [DC_N-1:0] dc_rs_q_ff [0:DC_N-1];
   logic [DC_N-1:0] dc_rp_q_ff [0:DC_N-1];
   logic [45:0]     dc_ss_ff [0:DC_N-1];
   logic [45:0]     dc_sp_ff [0:DC_N-1];
   logic            dc_tir_ff [0:DC_N-1];
   logic            dc_valid_ff [0:DC_N-1];
   for (genvar g = 0; g < DC_N; g++) begin : g_div_c
      localparam int K = DC_N - 1 - g;
      logic [61:0]     rs_src, rp_src, dsh_s, dsh_p;
      logic [DC_N-1:0] qs_src, qp_src;
      logic [45:0]     ss_src, sp_src;
      logic            tir_src, valid_src, ge_s, ge_p;
      if (g == 0) begin : g_first
         assign rs_src = s7_rs_rem_ff;
         assign rp_src = s7_rp_rem_ff;
         assign qs_src = '0;
         assign qp_src = '0;
         assign ss_src = s7_ss_ff;
         assign sp_src = s7_sp_ff;
         assign tir_src = s7_tir_ff;
         assign valid_src = s7_valid_ff;
      end else begin : g_next
         assign rs_src = dc_rs_rem_ff[g-1];
         assign rp_src = dc_rp_rem_ff[g-1];
         assign qs_src = dc_rs_q_ff[g-1];
         assign qp_src = dc_rp_q_ff[g-1];
         assign ss_src = dc_ss_ff[g-1];
         assign sp_src = dc_sp_ff[g-1];
         assign tir_src = dc_tir_ff[g-1];
         assign valid_src = dc_valid_ff[g-1];
      end
      assign dsh_s = 62'(ss_src) << K;
      assign dsh_p = 62'(sp_src) << K;
      assign ge_s = rs_src >= dsh_s;
      assign ge_p = rp_src >= dsh_p;
      always_ff @(posedge clock) begin
         if (reset) begin
            dc_valid_ff[g] <= 1'b0;
         end else if (adv) begin
            dc_valid_ff[g] <= valid_src;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dc_rs_rem_ff[g] <= ge_s ? rs_src - dsh_s : rs_src;
            dc_rp_rem_ff[g] <= ge_p ? rp_src - dsh_p : rp_src;
            dc_rs_q_ff[g] <= ge_s ? qs_src | (DC_N'(1) << K) : qs_src;
            dc_rp_q_ff[g] <= ge_p ? qp_src | (DC_N'(1) << K) : qp_src;
            dc_ss_ff[g] <= ss_src;
            dc_sp_ff[g] <= sp_src;
            dc_tir_ff[g] <= tir_src;
         end
      end
   end

   // stage 8: coefficients, a zero sum counts as full reflection
   logic        s8_valid_ff, s8_tir_ff, s8_zs_ff, s8_zp_ff;
   logic [16:0] s8_rs_ff, s8_rp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (adv) begin
         s8_valid_ff <= dc_valid_ff[DC_N-1];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s8_zs_ff <= dc_ss_ff[DC_N-1] == '0;
         s8_zp_ff <= dc_sp_ff[DC_N-1] == '0;
         s8_rs_ff <= (dc_ss_ff[DC_N-1] == '0) ? 17'h10000 : dc_rs_q_ff[DC_N-1];
         s8_rp_ff <= (dc_sp_ff[DC_N-1] == '0) ? 17'h10000 : dc_rp_q_ff[DC_N-1];
         s8_tir_ff <= dc_tir_ff[DC_N-1];
      end
   end

   // stage 9: squared coefficients
   logic        s9_valid_ff, s9_tir_ff;
   logic [33:0] s9_qs_ff, s9_qp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (adv) begin
         s9_valid_ff <= s8_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s9_qs_ff <= {17'b0, s8_rs_ff} * {17'b0, s8_rs_ff};
         s9_qp_ff <= {17'b0, s8_rp_ff} * {17'b0, s8_rp_ff};
         s9_tir_ff <= s8_tir_ff;
      end
   end

   // output register: rounded mean, saturation, total internal reflection
   logic [34:0] tot_in;
   logic [16:0] mean_in;
   rsp_type     out_in;
   rsp_type     out_data_ff;
   assign tot_in = 35'(s9_qs_ff) + 35'(s9_qp_ff) + (35'(1) << 17);
   assign mean_in = tot_in[34:18];
   always_comb begin
      out_in.total_internal = s9_tir_ff;
      priority if (s9_tir_ff || mean_in > 17'(FULL_Q15)) begin
         out_in.reflectance = FULL_Q15;
      end else begin
         out_in.reflectance = mean_in[15:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s9_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   // checks
   `FR_ASSERT(a_tir_full, clock, reset, rsp_valid && rsp_data.total_internal |-> rsp_data.reflectance == FULL_Q15)
   `FR_ASSERT(a_sat, clock, reset, rsp_valid |-> rsp_data.reflectance <= FULL_Q15)
   `FR_ASSERT(a_no_zero_sum, clock, reset, s8_valid_ff && !s8_tir_ff |-> !s8_zs_ff && !s8_zp_ff)
   `FR_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid)

endmodule

// ===== src/fr_isqrt.sv =====
// pipelined integer square root, one root bit per stage
// depends on fr_pkg
module fr_isqrt #(
   parameter int SIDE_W = fr_pkg::SQRT_SIDE_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [fr_pkg::RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [fr_pkg::ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0]         out_side
);
   import fr_pkg::*;

   localparam int N = ROOT_W;
   localparam int RW = RAD_W + 1;

   logic [RAD_W-1:0]  rem_ff [0:N-1];
   logic [RW-1:0]     root_ff [0:N-1];
   logic [SIDE_W-1:0] side_ff [0:N-1];
   logic              valid_ff [0:N-1];

   for (genvar g = 0; g < N; g++) begin : g_stage
      logic [RAD_W-1:0]  rem_src;
      logic [RW-1:0]     root_src;
      logic [SIDE_W-1:0] side_src;
      logic              valid_src;
      logic [RW-1:0]     bit_c;
      logic [RW-1:0]     trial;
      logic              ge;
      logic [RAD_W-1:0]  rem_in;
      logic [RW-1:0]     root_in;

      if (g == 0) begin : g_first
         assign rem_src = in_rad;
         assign root_src = '0;
         assign side_src = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign root_src = root_ff[g-1];
         assign side_src = side_ff[g-1];
         assign valid_src = valid_ff[g-1];
      end

      // trial subtract of root plus the current power of four
      assign bit_c = RW'(1) << (2 * (N - 1 - g));
      assign trial = root_src + bit_c;
      assign ge = {1'b0, rem_src} >= trial;
      assign rem_in = ge ? rem_src - trial[RAD_W-1:0] : rem_src;
      assign root_in = ge ? (root_src >> 1) + bit_c : root_src >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (adv) begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g] <= rem_in;
            root_ff[g] <= root_in;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root = root_ff[N-1][ROOT_W-1:0];
   assign out_side = side_ff[N-1];

endmodule

// ===== tb/fresnel_reflectance_check.sv =====
// checker for the fresnel reflectance pipeline: watches both channels,
// predicts each result from the accepted ray hit and compares; uses fr_pkg
`timescale 1ns / 1ps
module fresnel_reflectance_check (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_stall,
   input  fr_pkg::req_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  fr_pkg::rsp_type rsp_data,
   output int              fail_count,
   output int              pending_count,
   output int              tir_count,
   output int              result_count
);
   import fr_pkg::*;

   rsp_type pending_results[$];

   // integer square root, floor
   function automatic logic [63:0] floor_root(input logic [63:0] radicand);
      logic [63:0] root, bit_pos, rem;
      root = 0;
      rem = radicand;
      bit_pos = 64'd1 << 62;
      while (bit_pos > rem) bit_pos = bit_pos >> 2;
      while (bit_pos != 0) begin
         if (rem >= root + bit_pos) begin
            rem = rem - (root + bit_pos);
            root = (root >> 1) + bit_pos;
         end else begin
            root = root >> 1;
         end
         bit_pos = bit_pos >> 2;
      end
      return root;
   endfunction

   // |p - q| / (p + q) in q.16, full reflection on a zero denominator
   function automatic logic [63:0] amp_coef(input logic [63:0] p, input logic [63:0] q);
      logic [63:0] diff, total;
      diff = (p > q) ? p - q : q - p;
      total = p + q;
      if (total == 0) return 64'd1 << 16;
      return (diff << 16) / total;
   endfunction

   // expected reflectance for one ray hit
   function automatic rsp_type fresnel_predict(input req_type hit);
      longint signed cosine;
      logic [63:0] idx, eta_i, eta_t, c, sin_i, sin_t, cos_t, rs, rp, avg;
      rsp_type res;
      cosine = longint'(hit.dir_x) * longint'(hit.norm_x)
             + longint'(hit.dir_y) * longint'(hit.norm_y)
             + longint'(hit.dir_z) * longint'(hit.norm_z);
      idx = {48'd0, hit.refr_index};
      if (idx == 0) idx = 1;
      if (cosine > (64'sd1 <<< 28)) cosine = 64'sd1 <<< 28;
      if (cosine < -(64'sd1 <<< 28)) cosine = -(64'sd1 <<< 28);
      // ray inside the surface swaps the indices
      if (cosine > 0) begin
         eta_i = idx;
         eta_t = {48'd0, UNITY_Q12};
      end else begin
         eta_i = {48'd0, UNITY_Q12};
         eta_t = idx;
      end
      c = (cosine < 0) ? -cosine : cosine;
      sin_i = floor_root((64'd1 << 56) - c * c);
      sin_t = (eta_i * sin_i) / eta_t;
      if (sin_t >= (64'd1 << 28)) begin
         res.reflectance = FULL_Q15;
         res.total_internal = 1'b1;
         return res;
      end
      cos_t = floor_root((64'd1 << 56) - sin_t * sin_t);
      rs = amp_coef(eta_t * c, eta_i * cos_t);
      rp = amp_coef(eta_i * c, eta_t * cos_t);
      avg = (rs * rs + rp * rp + (64'd1 << 17)) >> 18;
      if (avg > 64'd32768) avg = 64'd32768;
      res.reflectance = avg[15:0];
      res.total_internal = 1'b0;
      return res;
   endfunction

   assign pending_count = pending_results.size();

   // predict on accepted hits, compare accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count <= 0;
         tir_count <= 0;
         result_count <= 0;
      end else begin
         if (req_valid && !req_stall) pending_results.push_back(fresnel_predict(req_data));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (rsp_data.total_internal) tir_count <= tir_count + 1;
            if (pending_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_results.pop_front();
               if (want.reflectance !== rsp_data.reflectance ||
                   want.total_internal !== rsp_data.total_internal) begin
                  if (fail_count < 10)
                     $display("mismatch: expected refl %0d tir %0d, got refl %0d tir %0d",
                              want.reflectance, want.total_internal,
                              rsp_data.reflectance, rsp_data.total_internal);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/fresnel_reflectance_test.sv =====
// top of the fresnel reflectance testbench: clock, reset, stimulus, verdict
// depends on fr_pkg, fresnel_reflectance and fresnel_reflectance_check
`timescale 1ns / 1ps
module fresnel_reflectance_test;
   import fr_pkg::*;

   localparam int LATENCY = 113;
   localparam int RANDOM_HITS = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count, tir_count, result_count;
   int      hit_count = 0;
   logic    hold_off = 1'b0;

   always #6 clock = ~clock;

   fresnel_reflectance dut (.*);
   fresnel_reflectance_check checker_unit (.*);

   // random unit-ish vector component
   function automatic logic [15:0] rand_comp();
      return 16'($signed($urandom_range(32768, 0)) - 16384);
   endfunction

   // roughly unit vector built from a random pair plus the remainder
   task automatic rand_unit(output logic [15:0] x, output logic [15:0] y,
                            output logic [15:0] z);
      int a, b, rem;
      a = $urandom_range(32768, 0) - 16384;
      b = $urandom_range(32768, 0) - 16384;
      rem = 16384 * 16384 - a * a - b * b;
      if (rem < 0) begin
         b = 0;
         rem = 16384 * 16384 - a * a;
      end
      x = 16'(a);
      y = 16'(b);
      z = 16'($rtoi($sqrt(real'(rem))));
      if ($urandom_range(1, 0)) z = -z;
   endtask

   // offer one hit and wait until it is accepted, with random gaps
   task automatic send_hit(input req_type hit);
      req_valid <= 1'b1;
      req_data <= hit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      hit_count++;
      if ($urandom_range(7, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   function automatic req_type make_hit(input int dx, dy, dz, nx, ny, nz, idx);
      req_type h;
      h.dir_x = 16'(dx); h.dir_y = 16'(dy); h.dir_z = 16'(dz);
      h.norm_x = 16'(nx); h.norm_y = 16'(ny); h.norm_z = 16'(nz);
      h.refr_index = 16'(idx);
      return h;
   endfunction

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int mode;
      forever begin
         @(posedge clock);
         mode = $urandom_range(9, 0);
         if (hold_off) rsp_stall <= 1'b1;
         else if (mode < 4) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(3, 0) == 0);
      end
   end

   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_type hit;
      int burst;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: head-on, grazing, inside, index extremes, zero index, unnormalized
      send_hit(make_hit(0, 0, -16384, 0, 0, 16384, 6144));
      send_hit(make_hit(0, 0, 16384, 0, 0, 16384, 6144));
      send_hit(make_hit(16384, 0, 0, 0, 0, 16384, 6144));
      send_hit(make_hit(-16384, 0, 0, 0, 0, 16384, 256));
      send_hit(make_hit(0, 0, -16384, 0, 0, 16384, 65535));
      send_hit(make_hit(0, 0, 16384, 0, 0, 16384, 65535));
      send_hit(make_hit(11585, 0, 11585, 0, 0, 16384, 6144));
      send_hit(make_hit(11585, 0, 11585, 0, 0, 16384, 256));
      send_hit(make_hit(0, 0, -16384, 0, 0, 16384, 0));
      send_hit(make_hit(0, 0, 16384, 0, 0, 16384, 0));
      send_hit(make_hit(0, 0, 16384, 0, 0, 16384, 4096));
      send_hit(make_hit(-32768, -32768, -32768, 32767, 32767, 32767, 5000));
      send_hit(make_hit(32767, 32767, 32767, 32767, 32767, 32767, 5000));
      send_hit(make_hit(-1, 16384, 0, 16384, 0, 0, 4096));
      send_hit(make_hit(0, 0, 0, 0, 0, 0, 65535));
      send_hit(make_hit(32767, -32768, 1, -32768, 32767, -1, 43690));

      // pressure: long receiver hold-off while hits keep coming
      hold_off <= 1'b1;
      fork
         begin repeat (400) @(posedge clock); hold_off <= 1'b0; end
         repeat (200) send_hit(make_hit(rand_comp(), rand_comp(), rand_comp(),
                                        rand_comp(), rand_comp(), rand_comp(),
                                        $urandom_range(65535, 0)));
      join
      req_valid <= 1'b0;
      // sender pause until everything drained
      while (pending_count != 0) @(posedge clock);

      // random bursts: mostly unit vectors, some raw noise
      while (hit_count < RANDOM_HITS) begin
         burst = $urandom_range(40, 1);
         repeat (burst) begin
            if ($urandom_range(4, 0) != 0) begin
               rand_unit(hit.dir_x, hit.dir_y, hit.dir_z);
               rand_unit(hit.norm_x, hit.norm_y, hit.norm_z);
               hit.refr_index = ($urandom_range(3, 0) != 0) ?
                                16'($urandom_range(12288, 2048)) :
                                16'($urandom_range(65535, 0));
            end else begin
               hit = make_hit(rand_comp(), rand_comp(), rand_comp(),
                              rand_comp(), rand_comp(), rand_comp(),
                              $urandom_range(65535, 0));
               if ($urandom_range(3, 0) == 0)
                  hit = req_type'(112'({$urandom, $urandom, $urandom, $urandom}));
            end
            send_hit(hit);
         end
         req_valid <= 1'b0;
         repeat ($urandom_range(20, 0)) @(posedge clock);
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      $display("sent %0d ray hits, %0d results, %0d with total internal reflection",
               hit_count, result_count, tir_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
